@@ rtl/etc1_block_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// etc1 block decoder assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ETC1_BLOCK_DECODER_ASSERT_SVH
`define ETC1_BLOCK_DECODER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define ETC1_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("etc1 assertion failed");

// next-cycle implication, checked out of reset
`define ETC1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etc1 assertion failed");

`else

`define ETC1_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ETC1_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/etc1_pkg.sv @@
// ----------------------------------------------------------------------------
// etc1 package
// shared types, constants and decode helpers of the etc1 block decoder
// ----------------------------------------------------------------------------
package etc1_pkg;

    // default depth of the descriptor queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // decoded block, everything the back end needs to emit 16 texels
    typedef struct packed {
        t_rgb        base0;
        t_rgb        base1;
        logic [2:0]  cw0;
        logic [2:0]  cw1;
        logic        flip;
        logic [15:0] idx_lo;
        logic [15:0] idx_hi;
    } t_block_desc;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // modifier magnitude for a table row, small or large column
    function automatic logic [7:0] mod_mag(input logic [2:0] cw, input logic is_large);
        logic [7:0] mag;
        unique case (cw)
            3'd0: mag = is_large ? 8'd8   : 8'd2;
            3'd1: mag = is_large ? 8'd17  : 8'd5;
            3'd2: mag = is_large ? 8'd29  : 8'd9;
            3'd3: mag = is_large ? 8'd42  : 8'd13;
            3'd4: mag = is_large ? 8'd60  : 8'd18;
            3'd5: mag = is_large ? 8'd80  : 8'd24;
            3'd6: mag = is_large ? 8'd106 : 8'd33;
            3'd7: mag = is_large ? 8'd183 : 8'd47;
            default: mag = 8'd0;
        endcase
        return mag;
    endfunction

    // expand one channel byte into both half bases: {base0, base1}
    function automatic logic [15:0] expand_pair(input logic [7:0] f, input logic diff);
        logic [4:0] c1;
        logic [4:0] c2;
        logic [15:0] res;
        c1 = f[7:3];
        c2 = c1 + {{2{f[2]}}, f[2:0]};
        if (diff) begin
            res = {c1, c1[4:2], c2, c2[4:2]};
        end else begin
            res = {f[7:4], f[7:4], f[3:0], f[3:0]};
        end
        return res;
    endfunction

endpackage

@@ rtl/etc1_front.sv @@
// ----------------------------------------------------------------------------
// etc1 front end
// accepts a raw block, decodes mode and bases into a descriptor register
// ----------------------------------------------------------------------------
module etc1_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [63:0]           i_block_word,
    output logic                  o_desc_valid,
    input  logic                  i_desc_ready,
    output etc1_pkg::t_block_desc o_desc
);

    logic                  r_valid;
    etc1_pkg::t_block_desc r_desc;
    etc1_pkg::t_block_desc n_desc;
    logic [15:0]           red_pair;
    logic [15:0]           grn_pair;
    logic [15:0]           blu_pair;
    logic                  take;

    // base expansion for both halves
    always_comb begin
        red_pair      = etc1_pkg::expand_pair(i_block_word[63:56], i_block_word[33]);
        grn_pair      = etc1_pkg::expand_pair(i_block_word[55:48], i_block_word[33]);
        blu_pair      = etc1_pkg::expand_pair(i_block_word[47:40], i_block_word[33]);
        n_desc.base0  = '{r: red_pair[15:8], g: grn_pair[15:8], b: blu_pair[15:8]};
        n_desc.base1  = '{r: red_pair[7:0], g: grn_pair[7:0], b: blu_pair[7:0]};
        n_desc.cw0    = i_block_word[39:37];
        n_desc.cw1    = i_block_word[36:34];
        n_desc.flip   = i_block_word[32];
        n_desc.idx_lo = i_block_word[15:0];
        n_desc.idx_hi = i_block_word[31:16];
    end

    // stage is free when empty or draining into the queue
    assign o_ready      = !r_valid || i_desc_ready;
    assign take         = i_valid && o_ready;
    assign o_desc_valid = r_valid;
    assign o_desc       = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_desc <= n_desc;
        end
    end

endmodule

@@ rtl/etc1_queue.sv @@
// ----------------------------------------------------------------------------
// etc1 descriptor queue
// small fifo that decouples the front end from the texel back end
// ----------------------------------------------------------------------------
module etc1_queue #(
    parameter int unsigned DEPTH = etc1_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  etc1_pkg::t_block_desc i_push_desc,
    input  logic                  i_pop,
    output etc1_pkg::t_block_desc o_head,
    output etc1_pkg::t_q_status   o_status
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [LW-1:0] FULL_LVL = LW'(DEPTH);

    etc1_pkg::t_block_desc r_mem [DEPTH];
    logic [PW-1:0]         r_wr_ptr;
    logic [PW-1:0]         r_rd_ptr;
    logic [LW-1:0]         r_level;
    logic                  do_push;
    logic                  do_pop;

    assign o_status.empty = (r_level == '0);
    assign o_status.full  = (r_level == FULL_LVL);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + 1'b1;
            end else if (do_pop && !do_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

endmodule

@@ rtl/etc1_back.sv @@
// ----------------------------------------------------------------------------
// etc1 back end
// walks 16 texels per descriptor into an output register, one per unstalled cycle
// ----------------------------------------------------------------------------
module etc1_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  etc1_pkg::t_block_desc i_head,
    input  etc1_pkg::t_q_status   i_q_status,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_texel_x,
    output logic [1:0]            o_texel_y,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic                  o_last_texel
);

    logic                  r_busy;
    logic [3:0]            r_k;
    etc1_pkg::t_block_desc r_desc;
    logic                  r_out_valid;
    logic [1:0]            r_x;
    logic [1:0]            r_y;
    etc1_pkg::t_rgb        r_rgb;
    logic                  r_last;

    logic                  out_load;
    logic                  step;
    logic [1:0]            cur_x;
    logic [1:0]            cur_y;
    logic [3:0]            pix;
    logic [1:0]            idx;
    logic [7:0]            mag;
    etc1_pkg::t_rgb        base;
    etc1_pkg::t_rgb        n_rgb;

    // base plus or minus modifier, saturated to 0..255
    function automatic logic [7:0] add_clamp(input logic [7:0] b, input logic [7:0] m,
                                             input logic neg);
        logic [8:0] s;
        logic [7:0] res;
        if (neg) begin
            s   = {1'b0, b} - {1'b0, m};
            res = s[8] ? 8'd0 : s[7:0];
        end else begin
            s   = {1'b0, b} + {1'b0, m};
            res = s[8] ? 8'd255 : s[7:0];
        end
        return res;
    endfunction

    // output register takes a new texel when empty or being drained
    assign out_load = !r_out_valid || i_ready;
    assign step     = r_busy && out_load;
    assign o_pop    = !i_q_status.empty && (!r_busy || (step && (r_k == 4'd15)));

    // texel position, index and modifier
    always_comb begin
        cur_x = r_desc.flip ? r_k[1:0] : r_k[3:2];
        cur_y = r_desc.flip ? r_k[3:2] : r_k[1:0];
        pix   = {cur_x, cur_y};
        idx   = {r_desc.idx_hi[pix], r_desc.idx_lo[pix]};
        mag   = etc1_pkg::mod_mag(r_k[3] ? r_desc.cw1 : r_desc.cw0, idx[0]);
        base  = r_k[3] ? r_desc.base1 : r_desc.base0;
        n_rgb = '{r: add_clamp(base.r, mag, idx[1]),
                  g: add_clamp(base.g, mag, idx[1]),
                  b: add_clamp(base.b, mag, idx[1])};
    end

    // texel sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_k    <= '0;
        end else if (step) begin
            r_k <= r_k + 1'b1;
            if (r_k == 4'd15) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_head;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_busy;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_x    <= cur_x;
            r_y    <= cur_y;
            r_rgb  <= n_rgb;
            r_last <= (r_k == 4'd15);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_texel_x    = r_x;
    assign o_texel_y    = r_y;
    assign o_red        = r_rgb.r;
    assign o_green      = r_rgb.g;
    assign o_blue       = r_rgb.b;
    assign o_last_texel = r_last;

endmodule

@@ rtl/etc1_block_decoder.sv @@
// ----------------------------------------------------------------------------
// etc1 block decoder
// decodes one 64-bit etc1 block into its 16 rgb888 texels
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  block   | i_valid / o_ready  | i_block_word
//  texel   | o_valid / i_ready  | o_texel_x o_texel_y o_red o_green o_blue
//          |                    | o_last_texel
//
// a block request yields 16 texel requests, one per cycle while the output
// is taken; the back end's texel counter walks them.
// the first texel passes the front end register, the queue, the back end descriptor and output registers.
// the front end keeps taking blocks into the descriptor queue, until it is full,
// while the back end is busy or stalled on the output side.
// synchronous active-low reset clears valid flags, counters and queue pointers.
// ----------------------------------------------------------------------------
`include "etc1_block_decoder_assert.svh"

module etc1_block_decoder #(
    parameter int unsigned QUEUE_DEPTH = etc1_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_block_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_texel_x,
    output logic [1:0]  o_texel_y,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_last_texel
);

    logic                  desc_valid;
    etc1_pkg::t_block_desc front_desc;
    etc1_pkg::t_block_desc q_head;
    etc1_pkg::t_q_status   q_status;
    logic                  q_pop;

    // decode stage
    etc1_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_block_word (i_block_word),
        .o_desc_valid (desc_valid),
        .i_desc_ready (!q_status.full),
        .o_desc       (front_desc)
    );

    // descriptor queue
    etc1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (desc_valid),
        .i_push_desc (front_desc),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_status    (q_status)
    );

    // texel generation
    etc1_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_q_status   (q_status),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_texel_x    (o_texel_x),
        .o_texel_y    (o_texel_y),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_last_texel (o_last_texel)
    );

    // both scan orders end on the bottom-right texel
    `ETC1_ASSERT_IMPL(a_last_corner, i_clk, i_rst_n, o_valid && o_last_texel,
        (o_texel_x == 2'd3) && (o_texel_y == 2'd3))
    // queue never reports empty and full together
    `ETC1_ASSERT_IMPL(a_q_status, i_clk, i_rst_n, q_status.full, !q_status.empty)
    // back end only pops a loaded queue
    `ETC1_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, q_pop, !q_status.empty)
    // a stalled texel stays offered with its payload unchanged
    `ETC1_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable({o_texel_x, o_texel_y, o_red, o_green, o_blue, o_last_texel}))

endmodule

@@ bench/etc1_texel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etc1 texel checker
// watches the block and texel channels of the etc1 block decoder, decodes
// every accepted block on its own into the 16 texels it must produce, and
// compares each accepted texel field by field against the oldest one waiting
// ----------------------------------------------------------------------------
module etc1_texel_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_blk_valid,
    input  logic        i_blk_ready,
    input  logic [63:0] i_block_word,
    input  logic        i_tex_valid,
    input  logic        i_tex_ready,
    input  logic [1:0]  i_texel_x,
    input  logic [1:0]  i_texel_y,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_last_texel,
    output int          o_mismatch_count,
    output int          o_texels_pending
);

    typedef struct {
        logic [1:0]     x;
        logic [1:0]     y;
        etc1_pkg::t_rgb rgb;
        logic           last;
    } t_texel;

    t_texel expected_texels[$];
    int     mismatches = 0;

    // signed modifier: index bit 0 picks the large column, bit 1 negates
    function automatic int texel_modifier(input logic [2:0] cw, input logic [1:0] idx);
        int mag;
        case (cw)
            3'd0: mag = idx[0] ? 8   : 2;
            3'd1: mag = idx[0] ? 17  : 5;
            3'd2: mag = idx[0] ? 29  : 9;
            3'd3: mag = idx[0] ? 42  : 13;
            3'd4: mag = idx[0] ? 60  : 18;
            3'd5: mag = idx[0] ? 80  : 24;
            3'd6: mag = idx[0] ? 106 : 33;
            default: mag = idx[0] ? 183 : 47;
        endcase
        return idx[1] ? -mag : mag;
    endfunction

    function automatic logic [7:0] clamp_channel(input int v);
        if (v < 0) begin
            return 8'd0;
        end
        if (v > 255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    // decode one block into its 16 texels in output order
    function automatic void decode_block_texels(input logic [63:0] w);
        logic       diff;
        logic       flip;
        logic [2:0] cw [2];
        int         base [2][3];
        int         ch;
        int         top;
        int         k;
        int         m;
        logic [4:0] c1;
        logic [4:0] c2;
        logic [2:0] d;
        logic [3:0] kk;
        logic [1:0] x;
        logic [1:0] y;
        logic [3:0] p;
        logic [1:0] idx;
        logic       half;
        t_texel     t;

        diff  = w[33];
        flip  = w[32];
        cw[0] = w[39:37];
        cw[1] = w[36:34];

        // per-channel base colors of both halves
        for (ch = 0; ch < 3; ch++) begin
            top = 56 - 8 * ch;
            if (diff) begin
                c1 = w[top + 3 +: 5];
                d  = w[top +: 3];
                // 5-bit sum wraps around
                c2 = c1 + {{2{d[2]}}, d};
                base[0][ch] = (int'(c1) * 33) / 4;
                base[1][ch] = (int'(c2) * 33) / 4;
            end else begin
                base[0][ch] = int'(w[top + 4 +: 4]) * 17;
                base[1][ch] = int'(w[top +: 4]) * 17;
            end
        end

        // first half then second half, column-major unless flipped
        for (k = 0; k < 16; k++) begin
            kk   = k[3:0];
            x    = flip ? kk[1:0] : kk[3:2];
            y    = flip ? kk[3:2] : kk[1:0];
            half = kk[3];
            p    = {x, y};
            idx  = {w[16 + p], w[p]};
            m    = texel_modifier(cw[half], idx);
            t.x     = x;
            t.y     = y;
            t.rgb.r = clamp_channel(base[half][0] + m);
            t.rgb.g = clamp_channel(base[half][1] + m);
            t.rgb.b = clamp_channel(base[half][2] + m);
            t.last  = (k == 15);
            expected_texels.push_back(t);
        end
    endfunction

    // predict on block requests, compare on texel requests
    always @(posedge i_clk) begin
        t_texel want;
        if (i_rst_n) begin
            if (i_blk_valid && i_blk_ready) begin
                decode_block_texels(i_block_word);
            end
            if (i_tex_valid && i_tex_ready) begin
                if (expected_texels.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected texel, expected none, actual x=%0d y=%0d",
                             $time, i_texel_x, i_texel_y,
                             " rgb=%h %h %h last=%0b", i_red, i_green, i_blue,
                             i_last_texel);
                end else begin
                    want = expected_texels.pop_front();
                    if (want.x !== i_texel_x || want.y !== i_texel_y ||
                        want.rgb.r !== i_red || want.rgb.g !== i_green ||
                        want.rgb.b !== i_blue || want.last !== i_last_texel) begin
                        mismatches++;
                        $display("%0t: texel mismatch, expected x=%0d y=%0d rgb=%h %h %h",
                                 $time, want.x, want.y, want.rgb.r, want.rgb.g,
                                 want.rgb.b, " last=%0b", want.last,
                                 ", actual x=%0d y=%0d rgb=%h %h %h last=%0b",
                                 i_texel_x, i_texel_y, i_red, i_green, i_blue,
                                 i_last_texel);
                    end
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_texels_pending <= expected_texels.size();
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etc1 block decoder testbench
// drives directed and random etc1 blocks into the decoder under changing
// sender and receiver idle rates, with a long output stall and a full drain,
// while the texel checker predicts and compares every texel
// ----------------------------------------------------------------------------
module testbench;

    localparam int   RANDOM_BLOCKS     = 204;
    localparam int   RX_HOLD_CYCLES    = 300;
    localparam int   HOLD_AFTER_BLOCKS = 180;
    localparam int   DRAIN_CYCLES      = 20;

    localparam logic MODE_INDIVIDUAL = 1'b0;
    localparam logic MODE_DIFF       = 1'b1;
    localparam logic SPLIT_COLUMNS   = 1'b0;
    localparam logic SPLIT_ROWS      = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [63:0] i_block_word;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_texel_x;
    logic [1:0]  o_texel_y;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        o_last_texel;

    int mismatch_count;
    int texels_pending;
    int tx_idle_pct = 31;
    int rx_idle_pct = 84;
    int blocks_sent = 0;

    etc1_block_decoder DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_block_word (i_block_word),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_texel_x    (o_texel_x),
        .o_texel_y    (o_texel_y),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_last_texel (o_last_texel)
    );

    etc1_texel_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_blk_valid      (i_valid),
        .i_blk_ready      (o_ready),
        .i_block_word     (i_block_word),
        .i_tex_valid      (o_valid),
        .i_tex_ready      (i_ready),
        .i_texel_x        (o_texel_x),
        .i_texel_y        (o_texel_y),
        .i_red            (o_red),
        .i_green          (o_green),
        .i_blue           (o_blue),
        .i_last_texel     (o_last_texel),
        .o_mismatch_count (mismatch_count),
        .o_texels_pending (texels_pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // texel receiver: random stalls plus one long hold-off once traffic is dense
    initial begin
        bit held;
        held    = 1'b0;
        i_ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (!held && blocks_sent >= HOLD_AFTER_BLOCKS) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [63:0] pack_block(input logic [23:0] colors,
                                               input logic [2:0] cw1, input logic [2:0] cw2,
                                               input logic mode, input logic split,
                                               input logic [15:0] idx_hi,
                                               input logic [15:0] idx_lo);
        return {colors, cw1, cw2, mode, split, idx_hi, idx_lo};
    endfunction

    // random block, a share pushed to the color rails to hit clamping
    function automatic logic [63:0] random_block();
        logic [63:0] w;
        int          sel;
        w   = {$urandom, $urandom};
        sel = $urandom_range(7);
        if (sel == 0) begin
            w[63:40] = w[63:40] | 24'hF8F8F8;
            w[39:34] = 6'h3F;
        end else if (sel == 1) begin
            w[63:40] = w[63:40] & 24'h070707;
            w[39:34] = 6'h3F;
        end
        return w;
    endfunction

    // one block request, held until taken
    task automatic send_block(input logic [63:0] word);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_block_word <= word;
        do @(posedge i_clk); while (!o_ready);
        blocks_sent++;
    endtask

    // stimulus and verdict
    initial begin
        int n;
        logic [2:0] cw;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_block_word = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bit extremes, clamping both ways, delta wrap, every table row
        send_block(64'h0000_0000_0000_0000);
        send_block(64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'h5555_5555_5555_5555);
        send_block(64'hAAAA_AAAA_AAAA_AAAA);
        send_block(pack_block(24'hFFFFFF, 3'd7, 3'd7, MODE_INDIVIDUAL, SPLIT_COLUMNS,
                              16'h0000, 16'hFFFF));
        send_block(pack_block(24'h000000, 3'd7, 3'd7, MODE_INDIVIDUAL, SPLIT_ROWS,
                              16'hFFFF, 16'hFFFF));
        // 31 plus 3 wraps up, 0 minus 4 wraps down
        send_block(pack_block(24'hFBFBFB, 3'd0, 3'd3, MODE_DIFF, SPLIT_COLUMNS,
                              16'hAAAA, 16'hF0F0));
        send_block(pack_block(24'h040404, 3'd5, 3'd6, MODE_DIFF, SPLIT_ROWS,
                              16'hAAAA, 16'hF0F0));
        send_block(pack_block(24'h808080, 3'd4, 3'd2, MODE_DIFF, SPLIT_COLUMNS,
                              16'hAAAA, 16'hF0F0));
        // index pattern gives all four modifiers in each half for either split
        for (n = 0; n < 8; n++) begin
            cw = n[2:0];
            send_block(pack_block(24'h8A6C4E, cw, 3'd7 - cw,
                                  cw[0] ? MODE_DIFF : MODE_INDIVIDUAL,
                                  cw[1] ? SPLIT_ROWS : SPLIT_COLUMNS,
                                  16'hAAAA, 16'hF0F0));
        end

        for (n = 0; n < RANDOM_BLOCKS / 3; n++) begin
            send_block(random_block());
        end

        // sender pause until every texel is out
        i_valid <= 1'b0;
        do @(posedge i_clk); while (texels_pending != 0);

        tx_idle_pct = 84;
        rx_idle_pct = 31;
        for (n = 0; n < RANDOM_BLOCKS / 3; n++) begin
            send_block(random_block());
        end

        // no idling, the receiver hold-off lands in here
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (n = 0; n < RANDOM_BLOCKS - 2 * (RANDOM_BLOCKS / 3); n++) begin
            send_block(random_block());
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (texels_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && texels_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/etc1_pkg.sv
rtl/etc1_front.sv
rtl/etc1_queue.sv
rtl/etc1_back.sv
rtl/etc1_block_decoder.sv
bench/etc1_texel_checker.sv
bench/testbench.sv
